@@ hw/rtl/fts_pkg.sv @@
// shared types, verdict and class codes and the utf-8 lead byte decoder for the file type sniffer
// no dependencies; used by fts_scan, fts_match and the top level

package fts_pkg;

  localparam int POS_W     = 7;
  localparam int HDR_N     = 16;
  localparam int CLASS_W   = 5;
  localparam int TAR_SPAN_DEF = 100;

  typedef logic [HDR_N-1:0][7:0] hdr_t;

  // text scan verdict codes
  localparam logic [2:0] V_SCAN    = 3'd0;
  localparam logic [2:0] V_UNKNOWN = 3'd1;
  localparam logic [2:0] V_PENDING = 3'd2;
  localparam logic [2:0] V_TAR     = 3'd3;

  // file classes
  localparam logic [CLASS_W-1:0] C_UNKNOWN   = 5'd0;
  localparam logic [CLASS_W-1:0] C_TEXT      = 5'd1;
  localparam logic [CLASS_W-1:0] C_TAR       = 5'd2;
  localparam logic [CLASS_W-1:0] C_ZIP       = 5'd3;
  localparam logic [CLASS_W-1:0] C_RAR       = 5'd4;
  localparam logic [CLASS_W-1:0] C_DJVU      = 5'd5;
  localparam logic [CLASS_W-1:0] C_PDF       = 5'd6;
  localparam logic [CLASS_W-1:0] C_MSWORD    = 5'd7;
  localparam logic [CLASS_W-1:0] C_PNG       = 5'd8;
  localparam logic [CLASS_W-1:0] C_JPEG      = 5'd9;
  localparam logic [CLASS_W-1:0] C_GIF       = 5'd10;
  localparam logic [CLASS_W-1:0] C_BMP       = 5'd11;
  localparam logic [CLASS_W-1:0] C_MPEGAUDIO = 5'd12;
  localparam logic [CLASS_W-1:0] C_MPEGVIDEO = 5'd13;
  localparam logic [CLASS_W-1:0] C_OGG       = 5'd14;
  localparam logic [CLASS_W-1:0] C_MATROSKA  = 5'd15;
  localparam logic [CLASS_W-1:0] C_WAVE      = 5'd16;
  localparam logic [CLASS_W-1:0] C_AVI       = 5'd17;
  localparam logic [CLASS_W-1:0] C_ASF       = 5'd18;
  localparam logic [CLASS_W-1:0] C_QUICKTIME = 5'd19;
  localparam logic [CLASS_W-1:0] C_MP4       = 5'd20;
  localparam logic [CLASS_W-1:0] C_M4A       = 5'd21;
  localparam logic [CLASS_W-1:0] C_M4V       = 5'd22;
  localparam logic [CLASS_W-1:0] C_3GPP      = 5'd23;

  // text scan result handed to the top level
  typedef struct packed {
    logic                 long_enough;
    logic [CLASS_W-1:0]   text_class;
  } scan_view_t;

  // continuation bytes due after a lead byte; valid clear means not text
  typedef struct packed {
    logic       valid;
    logic [2:0] count;
  } lead_t;

  function automatic lead_t lead_kind(input logic [7:0] b);
    lead_t r;
    r.valid = 1'b1;
    r.count = 3'd0;
    if (b == 8'h09 || b == 8'h0a || b == 8'h0d) r.count = 3'd0;
    else if (b >= 8'h20 && b <= 8'h7e) r.count = 3'd0;
    else if (b >= 8'hc0 && b <= 8'hdf) r.count = 3'd1;
    else if (b >= 8'he0 && b <= 8'hef) r.count = 3'd2;
    else if (b >= 8'hf0 && b <= 8'hf7) r.count = 3'd3;
    else if (b >= 8'hf8 && b <= 8'hfb) r.count = 3'd4;
    else if (b == 8'hfc || b == 8'hfd) r.count = 3'd5;
    else r.valid = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/fts_scan.sv @@
// header store, byte position and utf-8 / nul-run text scan
// depends on fts_pkg

module fts_scan #(
  parameter int TAR_SPAN = fts_pkg::TAR_SPAN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output fts_pkg::hdr_t      hdr_view,
  output fts_pkg::scan_view_t view
);
  import fts_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] TAR_LAST = POS_W'(TAR_SPAN - 1);
  localparam logic [POS_W-1:0] HDR_END  = POS_W'(HDR_N);

  hdr_t             header;
  logic [POS_W-1:0] position, position_next;
  logic [2:0]       cont_left, cont_left_next;
  logic [2:0]       verdict, verdict_next;
  logic             wr_hdr;
  lead_t            lead;

  assign wr_hdr = (position < HDR_END);
  assign lead   = lead_kind(data_byte);

  // header as it stands once the current item is stored
  always_comb begin
    for (int i = 0; i < HDR_N; i++) begin
      hdr_view[i] = (wr_hdr && position[3:0] == 4'(i)) ? data_byte : header[i];
    end
  end

  always_comb begin
    verdict_next   = verdict;
    cont_left_next = cont_left;
    unique case (verdict)
      V_SCAN: begin
        if (cont_left != 3'd0) begin
          if (data_byte[7:6] != 2'b10) verdict_next = V_UNKNOWN;
          else cont_left_next = cont_left - 3'd1;
        end else if (!lead.valid) begin
          if (data_byte != 8'h00) verdict_next = V_UNKNOWN;
          else if (position >= TAR_LAST) verdict_next = V_TAR;
          else verdict_next = V_PENDING;
        end else begin
          cont_left_next = lead.count;
        end
      end
      V_PENDING: begin
        if (data_byte != 8'h00) verdict_next = V_UNKNOWN;
        else if (position >= TAR_LAST) verdict_next = V_TAR;
      end
      default: ;
    endcase
    position_next = (position != POS_MAX) ? position + POS_W'(1) : position;
  end

  always_comb begin
    view.long_enough = (position_next >= HDR_END);
    if (verdict_next == V_TAR) view.text_class = C_TAR;
    else if (verdict_next == V_SCAN && cont_left_next == 3'd0) view.text_class = C_TEXT;
    else view.text_class = C_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      cont_left <= 3'd0;
      verdict   <= V_SCAN;
    end else if (step) begin
      if (last_byte) begin
        position  <= '0;
        cont_left <= 3'd0;
        verdict   <= V_SCAN;
      end else begin
        position  <= position_next;
        cont_left <= cont_left_next;
        verdict   <= verdict_next;
      end
    end
  end

  // header entries carry no reset; read only once all have been written
  always_ff @(posedge clk) begin
    if (step && wr_hdr) begin
      header[position[3:0]] <= data_byte;
    end
  end

endmodule

@@ hw/rtl/fts_match.sv @@
// magic signature matcher over the first sixteen header bytes
// depends on fts_pkg

module fts_match (
  input  fts_pkg::hdr_t               hdr,
  input  fts_pkg::scan_view_t         view,
  output logic [fts_pkg::CLASS_W-1:0] file_class
);
  import fts_pkg::*;

  logic [31:0] w0, w1, w2, w3, bsize;
  logic [15:0] h16;

  assign w0    = {hdr[0],  hdr[1],  hdr[2],  hdr[3]};
  assign w1    = {hdr[4],  hdr[5],  hdr[6],  hdr[7]};
  assign w2    = {hdr[8],  hdr[9],  hdr[10], hdr[11]};
  assign w3    = {hdr[12], hdr[13], hdr[14], hdr[15]};
  assign h16   = w0[31:16];
  assign bsize = {hdr[5], hdr[4], hdr[3], hdr[2]};

  always_comb begin
    file_class = view.text_class;
    if (view.long_enough) begin
      priority if ((w0 & 32'hffffff00) == 32'hffd8ff00) file_class = C_JPEG;
      else if (w0 == 32'h89504e47 && w1 == 32'h0d0a1a0a) file_class = C_PNG;
      else if (w0 == 32'h47494638 && (w1[31:16] == 16'h3761 || w1[31:16] == 16'h3961))
        file_class = C_GIF;
      else if ((w0 & 32'hffffff00) == 32'h0 && w1 == 32'h66747970 &&
               (w2 == 32'h71742020 || w2 == 32'h61766331 || w2 == 32'h69736f32 ||
                w2 == 32'h69736f6d || w2 == 32'h6d703431 || w2 == 32'h6d703432 ||
                w2 == 32'h4d344120 || w2 == 32'h4d345620 || w2 == 32'h33677034 ||
                w2 == 32'h33677035 || w2 == 32'h33677036)) begin
        // brand picks the flavor; unlisted brands fall through to the later checks
        priority if (w2 == 32'h71742020) file_class = C_QUICKTIME;
        else if (w2 == 32'h4d344120) file_class = C_M4A;
        else if (w2 == 32'h4d345620) file_class = C_M4V;
        else if (w2[31:8] == 24'h336770) file_class = C_3GPP;
        else file_class = C_MP4;
      end
      else if (w0 == 32'h1a45dfa3) file_class = C_MATROSKA;
      else if ((h16 & 16'hfff6) == 16'hfff2 || (h16 & 16'hfff6) == 16'hfff4 ||
               w0[31:8] == 24'h494433 ||
               (w0 == 32'h0 && w1 == 32'h0 && w2 == 32'h0 && w3 == 32'h0))
        file_class = C_MPEGAUDIO;
      else if (w0 == 32'h000001ba) file_class = C_MPEGVIDEO;
      else if (w0 == 32'h4f676753 && hdr[4] == 8'h00) file_class = C_OGG;
      else if (w0 == 32'h52494646 && w2 == 32'h57415645) file_class = C_WAVE;
      else if (w0 == 32'h52494646 && w2 == 32'h41564920) file_class = C_AVI;
      else if (w0 == 32'h3026b275 && w1 == 32'h8e66cf11 &&
               w2 == 32'ha6d900aa && w3 == 32'h0062ce6c) file_class = C_ASF;
      else if (w0 == 32'h504b0304 || w0 == 32'h504b0506 || w0 == 32'h504b0708)
        file_class = C_ZIP;
      else if (w0 == 32'h52617221) file_class = C_RAR;
      else if (h16 == 16'h1f8b) file_class = C_TAR;
      else if ((w0 & 32'hfffffff0) == 32'h425a6830) file_class = C_TAR;
      else if (w0 == 32'h25504446) file_class = C_PDF;
      else if (w0 == 32'hd0cf11e0 && w1 == 32'ha1b11ae1) file_class = C_MSWORD;
      else if (w0 == 32'h41542654 && w1 == 32'h464f524d) file_class = C_DJVU;
      else if (h16 == 16'h424d && bsize >= 32'd26) file_class = C_BMP;
      else file_class = view.text_class;
    end
  end

endmodule

@@ hw/rtl/file_type_signature_sniffer.sv @@
// top level of the file type sniffer: input register, scan and matcher, result register
// depends on fts_pkg, fts_scan and fts_match

// Takes one file byte per item from offset zero, last_byte marking the final one, and
// gives one file_class item for each stream; class_valid rises once the final byte reaches
// the result register. It accepts a byte in every cycle while data_stall is low; the update
// of position and utf-8 state in the scan registers sets that rate. While a class is held
// by class_stall the input register still takes one more byte; data_stall rises only when
// a class is held by class_stall and the input register is full, and falls once it is taken.

module file_type_signature_sniffer #(
  parameter int TAR_SPAN = fts_pkg::TAR_SPAN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        class_valid,
  input  logic                        class_stall,
  output logic [fts_pkg::CLASS_W-1:0] file_class
);
  import fts_pkg::*;

  logic               s1_valid, s1_last;
  logic [7:0]         s1_byte;
  logic               advance, load;
  hdr_t               hdr_view;
  scan_view_t         view;
  logic [CLASS_W-1:0] class_comb;

  assign advance    = !class_valid || !class_stall;
  assign load       = !s1_valid || advance;
  assign data_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && data_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  fts_scan #(.TAR_SPAN(TAR_SPAN)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .hdr_view  (hdr_view),
    .view      (view)
  );

  fts_match u_match (
    .hdr        (hdr_view),
    .view       (view),
    .file_class (class_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= 1'b0;
    end else if (advance) begin
      class_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_last) begin
      file_class <= class_comb;
    end
  end

  // a byte that is not the final one never raises a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && !s1_last) |=> !class_valid)
    else $error("result raised by a non-final byte");

  // input is held back only when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> (s1_valid && class_valid && class_stall))
    else $error("input stalled with room to spare");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    class_valid |-> (file_class <= C_3GPP))
    else $error("file class out of range");

endmodule
